FILE: hdl/pci_pkg.sv
// Shared types and constants of the polygon corner intersector.
// Command and status words between controller and datapath, operand codes.
// No dependencies.
package pci_pkg;

	// configuration register
	localparam int LEN_W = 12;
	localparam logic [LEN_W-1:0] LEN_RESET = 12'd120;

	// result words
	localparam int RES_W = 16;
	localparam logic signed [RES_W-1:0] RES_MAX = 16'sh7FFF;
	localparam logic signed [RES_W-1:0] RES_MIN = 16'sh8000;

	// iterative divider: one overflow bit plus sixteen quotient bits
	localparam int QBITS = RES_W + 1;
	localparam int CNT_W = 5;
	localparam logic [QBITS-1:0] SAT_POS_MAG = 17'd32767;
	localparam logic [QBITS-1:0] SAT_NEG_MAG = 17'd32768;

	// kept line counter
	localparam int KCNT_W = 2;
	localparam logic [KCNT_W-1:0] KCNT_ZERO = 2'd0;
	localparam logic [KCNT_W-1:0] KCNT_ONE = 2'd1;
	localparam logic [KCNT_W-1:0] KCNT_TWO = 2'd2;

	// shared multiplier operand pairs
	localparam int MUL_W = 3;
	localparam logic [MUL_W-1:0] MUL_A_SX = 3'd0;
	localparam logic [MUL_W-1:0] MUL_B_SY = 3'd1;
	localparam logic [MUL_W-1:0] MUL_PA_QB = 3'd2;
	localparam logic [MUL_W-1:0] MUL_QA_PB = 3'd3;
	localparam logic [MUL_W-1:0] MUL_QB_PC = 3'd4;
	localparam logic [MUL_W-1:0] MUL_PB_QC = 3'd5;
	localparam logic [MUL_W-1:0] MUL_PA_QC = 3'd6;
	localparam logic [MUL_W-1:0] MUL_QA_PC = 3'd7;

	// accumulator operations
	localparam int ACC_W = 2;
	localparam logic [ACC_W-1:0] ACC_HOLD = 2'd0;
	localparam logic [ACC_W-1:0] ACC_LOAD = 2'd1;
	localparam logic [ACC_W-1:0] ACC_ADD = 2'd2;
	localparam logic [ACC_W-1:0] ACC_SUB = 2'd3;

	// line pair under test
	localparam logic PAIR_CONSEC = 1'b0;
	localparam logic PAIR_CLOSE = 1'b1;

	// divider numerator select
	localparam logic DIV_X = 1'b0;
	localparam logic DIV_Y = 1'b1;

	typedef struct packed {
		logic load_in;
		logic len_sq;
		logic mul_en;
		logic [MUL_W-1:0] mul_sel;
		logic [ACC_W-1:0] acc_op;
		logic c_load;
		logic first_load;
		logic prev_load;
		logic pair;
		logic det_load;
		logic nx_load;
		logic ny_load;
		logic div_start;
		logic div_sel;
		logic res_wx;
		logic res_wy;
		logic res_clr;
		logic buf_load;
	} pci_cmd_t;

	typedef struct packed {
		logic keep;
		logic closing;
		logic acc_zero;
		logic div_done;
		logic any_res;
		logic buf_empty;
	} pci_sts_t;

endpackage

FILE: hdl/pci_if.sv
// Valid/ready channel interfaces: segment input words and corner result words.
// Depends on pci_pkg for the result width.
interface pci_seg_if #(parameter int COORD_BITS = 12);
	logic valid;
	logic ready;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic closes_polygon;

	modport source (output valid, start_x, start_y, end_x, end_y, closes_polygon,
		input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, closes_polygon,
		output ready);
endinterface

interface pci_corner_if;
	logic valid;
	logic ready;
	logic signed [pci_pkg::RES_W-1:0] corner_x;
	logic signed [pci_pkg::RES_W-1:0] corner_y;
	logic is_closing_corner;
	logic last_of_run;

	modport source (output valid, corner_x, corner_y, is_closing_corner, last_of_run,
		input ready);
	modport sink (input valid, corner_x, corner_y, is_closing_corner, last_of_run,
		output ready);
endinterface

FILE: hdl/pci_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating, saturating to 16 bits.
// Depends on pci_pkg.
module pci_divider #(
	parameter int NUM_W = 42
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [NUM_W-1:0] den,
	output logic done,
	output logic signed [pci_pkg::RES_W-1:0] quo
);
	localparam int SH_W = NUM_W + pci_pkg::RES_W;

	logic [NUM_W-1:0] r_q;
	logic [SH_W-1:0] dsh_q;
	logic [pci_pkg::QBITS-1:0] q_q;
	logic neg_q;
	logic [pci_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [NUM_W-1:0] num_mag;
	logic [NUM_W-1:0] den_mag;
	logic ge;
	logic [pci_pkg::QBITS-1:0] q_neg;

	assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign den_mag = den[NUM_W-1] ? (~den + 1'b1) : den;
	assign ge = {{pci_pkg::RES_W{1'b0}}, r_q} >= dsh_q;
	assign q_neg = ~q_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= pci_pkg::CNT_W'(pci_pkg::QBITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// first step tests the quotient against 2^16: a set top bit means saturate
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= num_mag;
			dsh_q <= {den_mag, {pci_pkg::RES_W{1'b0}}};
			q_q <= '0;
			neg_q <= num[NUM_W-1] ^ den[NUM_W-1];
		end else if (busy_q) begin
			if (ge) begin
				r_q <= r_q - dsh_q[NUM_W-1:0];
			end
			q_q <= {q_q[pci_pkg::QBITS-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_comb begin
		if (neg_q) begin
			quo = (q_q > pci_pkg::SAT_NEG_MAG) ? pci_pkg::RES_MIN
				: $signed(q_neg[pci_pkg::RES_W-1:0]);
		end else begin
			quo = (q_q > pci_pkg::SAT_POS_MAG) ? pci_pkg::RES_MAX
				: $signed(q_q[pci_pkg::RES_W-1:0]);
		end
	end

	assign done = done_q;

endmodule

FILE: hdl/pci_datapath.sv
// Datapath: segment registers, length test, line store, shared multiplier,
// accumulator, divider and the two-word result buffer. Depends on pci_pkg, pci_divider.
module pci_datapath #(
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  pci_pkg::pci_cmd_t cmd,
	output pci_pkg::pci_sts_t sts,
	input  logic cfg_we,
	input  logic [pci_pkg::LEN_W-1:0] cfg_wdata,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic closes_polygon,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [pci_pkg::RES_W-1:0] out_x,
	output logic signed [pci_pkg::RES_W-1:0] out_y,
	output logic out_closing,
	output logic out_last
);
	localparam int KW = COORD_BITS + 1;
	localparam int CW = 2 * COORD_BITS + 3;
	localparam int PW = KW + CW;
	localparam int NW = PW + 1;
	localparam int SQW = (2 * KW + 1 > 2 * pci_pkg::LEN_W + 1) ? 2 * KW + 1
		: 2 * pci_pkg::LEN_W + 1;

	logic [pci_pkg::LEN_W-1:0] lim_q;
	logic [COORD_BITS-1:0] sx_q;
	logic [COORD_BITS-1:0] sy_q;
	logic closing_q;
	logic signed [KW-1:0] cur_a_q, cur_b_q;
	logic signed [CW-1:0] cur_c_q;
	logic signed [KW-1:0] first_a_q, first_b_q, prev_a_q, prev_b_q;
	logic signed [CW-1:0] first_c_q, prev_c_q;
	logic [2*KW-1:0] sqa_q, sqb_q;
	logic [2*pci_pkg::LEN_W-1:0] limsq_q;
	logic signed [PW-1:0] prod_q;
	logic signed [NW-1:0] acc_q, det_q, nx_q, ny_q;
	logic signed [pci_pkg::RES_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic ok0_q, ok1_q;
	logic signed [pci_pkg::RES_W-1:0] bx0_q, by0_q, bx1_q, by1_q;
	logic bv0_q, bv1_q, bl0_q;

	logic signed [2*KW-1:0] sqa, sqb;
	logic [SQW-1:0] len_sum;
	logic signed [KW-1:0] q_a, q_b;
	logic signed [CW-1:0] q_c;
	logic signed [KW-1:0] op_a;
	logic signed [CW-1:0] op_b;
	logic signed [NW-1:0] prod_ext;
	logic signed [NW-1:0] div_num;
	logic div_done;
	logic signed [pci_pkg::RES_W-1:0] div_quo;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= pci_pkg::LEN_RESET;
		end else if (cfg_we) begin
			lim_q <= cfg_wdata;
		end
	end

	// segment word and length test
	assign sqa = cur_a_q * cur_a_q;
	assign sqb = cur_b_q * cur_b_q;
	assign len_sum = SQW'(sqa_q) + SQW'(sqb_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sx_q <= start_x;
			sy_q <= start_y;
			closing_q <= closes_polygon;
			cur_a_q <= $signed({1'b0, end_y}) - $signed({1'b0, start_y});
			cur_b_q <= $signed({1'b0, start_x}) - $signed({1'b0, end_x});
		end
		if (cmd.len_sq) begin
			sqa_q <= sqa;
			sqb_q <= sqb;
			limsq_q <= lim_q * lim_q;
		end
		if (cmd.c_load) begin
			cur_c_q <= acc_q[CW-1:0];
		end
	end

	// line store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_a_q <= '0;
			first_b_q <= '0;
			first_c_q <= '0;
			prev_a_q <= '0;
			prev_b_q <= '0;
			prev_c_q <= '0;
		end else begin
			if (cmd.first_load) begin
				first_a_q <= cur_a_q;
				first_b_q <= cur_b_q;
				first_c_q <= cur_c_q;
			end
			if (cmd.prev_load) begin
				prev_a_q <= cur_a_q;
				prev_b_q <= cur_b_q;
				prev_c_q <= cur_c_q;
			end
		end
	end

	// p is always the previous line, q the new one or the first one
	assign q_a = (cmd.pair == pci_pkg::PAIR_CLOSE) ? first_a_q : cur_a_q;
	assign q_b = (cmd.pair == pci_pkg::PAIR_CLOSE) ? first_b_q : cur_b_q;
	assign q_c = (cmd.pair == pci_pkg::PAIR_CLOSE) ? first_c_q : cur_c_q;

	always_comb begin
		case (cmd.mul_sel)
			pci_pkg::MUL_A_SX: begin
				op_a = cur_a_q;
				op_b = $signed({{(CW-COORD_BITS){1'b0}}, sx_q});
			end
			pci_pkg::MUL_B_SY: begin
				op_a = cur_b_q;
				op_b = $signed({{(CW-COORD_BITS){1'b0}}, sy_q});
			end
			pci_pkg::MUL_PA_QB: begin
				op_a = prev_a_q;
				op_b = $signed({{(CW-KW){q_b[KW-1]}}, q_b});
			end
			pci_pkg::MUL_QA_PB: begin
				op_a = q_a;
				op_b = $signed({{(CW-KW){prev_b_q[KW-1]}}, prev_b_q});
			end
			pci_pkg::MUL_QB_PC: begin
				op_a = q_b;
				op_b = prev_c_q;
			end
			pci_pkg::MUL_PB_QC: begin
				op_a = prev_b_q;
				op_b = q_c;
			end
			pci_pkg::MUL_PA_QC: begin
				op_a = prev_a_q;
				op_b = q_c;
			end
			pci_pkg::MUL_QA_PC: begin
				op_a = q_a;
				op_b = prev_c_q;
			end
			default: begin
				op_a = cur_a_q;
				op_b = $signed({{(CW-COORD_BITS){1'b0}}, sx_q});
			end
		endcase
	end

	assign prod_ext = $signed({prod_q[PW-1], prod_q});

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		case (cmd.acc_op)
			pci_pkg::ACC_LOAD: acc_q <= prod_ext;
			pci_pkg::ACC_ADD: acc_q <= acc_q + prod_ext;
			pci_pkg::ACC_SUB: acc_q <= acc_q - prod_ext;
			default: acc_q <= acc_q;
		endcase
		if (cmd.det_load) begin
			det_q <= acc_q;
		end
		if (cmd.nx_load) begin
			nx_q <= acc_q;
		end
		if (cmd.ny_load) begin
			ny_q <= acc_q;
		end
	end

	assign div_num = (cmd.div_sel == pci_pkg::DIV_Y) ? ny_q : nx_q;

	pci_divider #(
		.NUM_W(NW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(div_num),
		.den(det_q),
		.done(div_done),
		.quo(div_quo)
	);

	// per-item results, slot picked by the pair under test
	always_ff @(posedge clk) begin
		if (cmd.res_wx) begin
			if (cmd.pair == pci_pkg::PAIR_CLOSE) begin
				x1_q <= div_quo;
			end else begin
				x0_q <= div_quo;
			end
		end
		if (cmd.res_wy) begin
			if (cmd.pair == pci_pkg::PAIR_CLOSE) begin
				y1_q <= div_quo;
			end else begin
				y0_q <= div_quo;
			end
		end
		if (cmd.buf_load) begin
			bx0_q <= x0_q;
			by0_q <= y0_q;
			bx1_q <= x1_q;
			by1_q <= y1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok0_q <= 1'b0;
			ok1_q <= 1'b0;
			bv0_q <= 1'b0;
			bv1_q <= 1'b0;
			bl0_q <= 1'b0;
		end else begin
			if (cmd.res_clr) begin
				ok0_q <= 1'b0;
				ok1_q <= 1'b0;
			end else if (cmd.res_wy) begin
				if (cmd.pair == pci_pkg::PAIR_CLOSE) begin
					ok1_q <= 1'b1;
				end else begin
					ok0_q <= 1'b1;
				end
			end
			// buffer loads only when empty, so load and pop never meet
			if (cmd.buf_load) begin
				bv0_q <= ok0_q;
				bv1_q <= ok1_q;
				bl0_q <= !ok1_q;
			end else if (out_valid && out_ready) begin
				if (bv0_q) begin
					bv0_q <= 1'b0;
				end else begin
					bv1_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = bv0_q | bv1_q;
	assign out_x = bv0_q ? bx0_q : bx1_q;
	assign out_y = bv0_q ? by0_q : by1_q;
	assign out_closing = !bv0_q;
	assign out_last = bv0_q ? bl0_q : 1'b1;

	assign sts.keep = len_sum > SQW'(limsq_q);
	assign sts.closing = closing_q;
	assign sts.acc_zero = (acc_q == '0);
	assign sts.div_done = div_done;
	assign sts.any_res = ok0_q | ok1_q;
	assign sts.buf_empty = !out_valid;

endmodule

FILE: hdl/pci_ctrl.sv
// Controller: sequences the length test, line forming, Cramer's rule products,
// divisions and result hand-off. Depends on pci_pkg.
module pci_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pci_pkg::pci_sts_t sts,
	output pci_pkg::pci_cmd_t cmd
);
	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] S_IDLE = 5'd0;
	localparam logic [ST_W-1:0] S_LEN = 5'd1;
	localparam logic [ST_W-1:0] S_KEEP = 5'd2;
	localparam logic [ST_W-1:0] S_C1 = 5'd3;
	localparam logic [ST_W-1:0] S_C2 = 5'd4;
	localparam logic [ST_W-1:0] S_C3 = 5'd5;
	localparam logic [ST_W-1:0] S_C4 = 5'd6;
	localparam logic [ST_W-1:0] S_C5 = 5'd7;
	localparam logic [ST_W-1:0] S_UPD = 5'd8;
	localparam logic [ST_W-1:0] S_CLOSE = 5'd9;
	localparam logic [ST_W-1:0] S_M1 = 5'd10;
	localparam logic [ST_W-1:0] S_M2 = 5'd11;
	localparam logic [ST_W-1:0] S_M3 = 5'd12;
	localparam logic [ST_W-1:0] S_M4 = 5'd13;
	localparam logic [ST_W-1:0] S_M5 = 5'd14;
	localparam logic [ST_W-1:0] S_M6 = 5'd15;
	localparam logic [ST_W-1:0] S_M7 = 5'd16;
	localparam logic [ST_W-1:0] S_M8 = 5'd17;
	localparam logic [ST_W-1:0] S_M9 = 5'd18;
	localparam logic [ST_W-1:0] S_M10 = 5'd19;
	localparam logic [ST_W-1:0] S_DX = 5'd20;
	localparam logic [ST_W-1:0] S_DY = 5'd21;
	localparam logic [ST_W-1:0] S_FIN = 5'd22;

	logic [ST_W-1:0] state_q, state_d;
	logic [pci_pkg::KCNT_W-1:0] kcnt_q, kcnt_d;
	logic pair_q, pair_d;
	logic [ST_W-1:0] meet_end;

	assign meet_end = (pair_q == pci_pkg::PAIR_CLOSE) ? S_FIN : S_UPD;

	always_comb begin
		state_d = state_q;
		kcnt_d = kcnt_q;
		pair_d = pair_q;
		cmd = '0;
		cmd.pair = pair_q;
		cmd.mul_sel = pci_pkg::MUL_A_SX;
		cmd.acc_op = pci_pkg::ACC_HOLD;
		cmd.div_sel = pci_pkg::DIV_X;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.res_clr = 1'b1;
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				cmd.len_sq = 1'b1;
				state_d = S_KEEP;
			end
			S_KEEP: begin
				state_d = sts.keep ? S_C1 : S_CLOSE;
			end
			// c = a*sx + b*sy
			S_C1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pci_pkg::MUL_A_SX;
				state_d = S_C2;
			end
			S_C2: begin
				cmd.acc_op = pci_pkg::ACC_LOAD;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pci_pkg::MUL_B_SY;
				state_d = S_C3;
			end
			S_C3: begin
				cmd.acc_op = pci_pkg::ACC_ADD;
				state_d = S_C4;
			end
			S_C4: begin
				cmd.c_load = 1'b1;
				state_d = S_C5;
			end
			S_C5: begin
				if (kcnt_q == pci_pkg::KCNT_ZERO) begin
					cmd.first_load = 1'b1;
					cmd.prev_load = 1'b1;
					kcnt_d = pci_pkg::KCNT_ONE;
					state_d = S_CLOSE;
				end else begin
					pair_d = pci_pkg::PAIR_CONSEC;
					state_d = S_M1;
				end
			end
			S_UPD: begin
				cmd.prev_load = 1'b1;
				kcnt_d = pci_pkg::KCNT_TWO;
				state_d = S_CLOSE;
			end
			S_CLOSE: begin
				if (sts.closing && (kcnt_q != pci_pkg::KCNT_ZERO)) begin
					pair_d = pci_pkg::PAIR_CLOSE;
					state_d = S_M1;
				end else begin
					state_d = S_FIN;
				end
			end
			// det = pa*qb - qa*pb
			S_M1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pci_pkg::MUL_PA_QB;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.acc_op = pci_pkg::ACC_LOAD;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pci_pkg::MUL_QA_PB;
				state_d = S_M3;
			end
			S_M3: begin
				cmd.acc_op = pci_pkg::ACC_SUB;
				state_d = S_M4;
			end
			// drop the pair on parallel lines; else nx = qb*pc - pb*qc
			S_M4: begin
				cmd.det_load = 1'b1;
				if (sts.acc_zero) begin
					state_d = meet_end;
				end else begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = pci_pkg::MUL_QB_PC;
					state_d = S_M5;
				end
			end
			S_M5: begin
				cmd.acc_op = pci_pkg::ACC_LOAD;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pci_pkg::MUL_PB_QC;
				state_d = S_M6;
			end
			S_M6: begin
				cmd.acc_op = pci_pkg::ACC_SUB;
				state_d = S_M7;
			end
			// ny = pa*qc - qa*pc
			S_M7: begin
				cmd.nx_load = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pci_pkg::MUL_PA_QC;
				state_d = S_M8;
			end
			S_M8: begin
				cmd.acc_op = pci_pkg::ACC_LOAD;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = pci_pkg::MUL_QA_PC;
				state_d = S_M9;
			end
			S_M9: begin
				cmd.acc_op = pci_pkg::ACC_SUB;
				state_d = S_M10;
			end
			S_M10: begin
				cmd.ny_load = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel = pci_pkg::DIV_X;
				state_d = S_DX;
			end
			S_DX: begin
				if (sts.div_done) begin
					cmd.res_wx = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = pci_pkg::DIV_Y;
					state_d = S_DY;
				end
			end
			S_DY: begin
				cmd.div_sel = pci_pkg::DIV_Y;
				if (sts.div_done) begin
					cmd.res_wy = 1'b1;
					state_d = meet_end;
				end
			end
			// with results to hand off, hold until the previous results have drained
			S_FIN: begin
				if (!sts.any_res || sts.buf_empty) begin
					cmd.buf_load = sts.any_res;
					if (sts.closing) begin
						kcnt_d = pci_pkg::KCNT_ZERO;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kcnt_q <= pci_pkg::KCNT_ZERO;
			pair_q <= pci_pkg::PAIR_CONSEC;
		end else begin
			state_q <= state_d;
			kcnt_q <= kcnt_d;
			pair_q <= pair_d;
		end
	end

endmodule

FILE: hdl/polygon_corner_intersector_unit.sv
// Corner intersector, one segment word in work at a time. A dropped segment ends after
// the length test, a kept one also forms its line; the pair with the previous line and the
// closing pair each add det, nx, ny through the multiplier and two divisions; a parallel
// pair stops at det. Corners leave a two-word buffer the next cycle; a later segment with
// corners holds at its end until the buffer drains. Uses pci_pkg, pci_if, pci_ctrl,
// pci_datapath. arst_n clears control, lines, buffer; limit resets to 120.
module polygon_corner_intersector_unit #(
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	pci_seg_if.sink seg,
	pci_corner_if.source corner,
	input  logic cfg_we,
	input  logic [pci_pkg::LEN_W-1:0] cfg_wdata
);
	// Flow of one segment word:
	//   accept -> square dx, dy and the limit -> compare
	//   kept: form c with the shared multiplier, then either store the first line
	//   of the polygon or intersect the previous line with this one
	//   closing: intersect the last kept line with the first line, clear the count
	// Each intersection runs det, nx, ny through one multiplier and accumulator,
	// then divides nx and ny by det in the iterative divider. A zero det drops
	// the pair right after det is known.

	pci_pkg::pci_cmd_t cmd;
	pci_pkg::pci_sts_t sts;
	logic in_ready;

	assign seg.ready = in_ready;

	pci_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(seg.valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	// datapath drives the corner word straight from its result buffer
	pci_datapath #(
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start_x(seg.start_x),
		.start_y(seg.start_y),
		.end_x(seg.end_x),
		.end_y(seg.end_y),
		.closes_polygon(seg.closes_polygon),
		.out_valid(corner.valid),
		.out_ready(corner.ready),
		.out_x(corner.corner_x),
		.out_y(corner.corner_y),
		.out_closing(corner.is_closing_corner),
		.out_last(corner.last_of_run)
	);

endmodule

FILE: hdl/pci_checker.sv
// Port-level checks of the corner intersector, attached by bind.
// Depends on polygon_corner_intersector_unit and its interface ports.
module pci_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_closing,
	input logic out_last
);

	// hold a stalled corner word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("corner word dropped while stalled");

	// one segment at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("segment accepted while one is in work");

	// closing corner always ends its run
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_closing |-> out_last)
		else $error("closing corner not marked last");

	// a word that is not last is followed at once by the closing corner
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_closing)
		else $error("second corner of a run missing");

endmodule

bind polygon_corner_intersector_unit pci_checker u_pci_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(seg.valid),
	.in_ready(seg.ready),
	.out_valid(corner.valid),
	.out_ready(corner.ready),
	.out_closing(corner.is_closing_corner),
	.out_last(corner.last_of_run)
);

FILE: test/polygon_corner_intersector_unit_tb.sv
// Testbench of polygon_corner_intersector_unit: streams boundary segments, predicts
// corner words with a scoreboard class and checks every word the block returns.
// Depends on pci_pkg, pci_if and the block's RTL.
`timescale 1ns / 100ps

module polygon_corner_intersector_unit_tb;

	localparam int CB = 12;
	localparam int CMAX = (1 << CB) - 1;
	localparam int PERIOD = 20;
	localparam int RESET_CYCLES = 6;
	// long enough for a segment alone to finish, with margin for the buffer
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 1500;
	localparam int WATCHDOG_LIMIT = 10000;

	typedef struct packed {
		logic [CB-1:0] sx;
		logic [CB-1:0] sy;
		logic [CB-1:0] ex;
		logic [CB-1:0] ey;
		logic closes;
	} segment_t;

	typedef struct packed {
		logic signed [pci_pkg::RES_W-1:0] x;
		logic signed [pci_pkg::RES_W-1:0] y;
		logic closing;
		logic tail;
	} corner_t;

	// line a*x + b*y = c
	typedef struct {
		longint a;
		longint b;
		longint c;
	} line_t;

	// Predicts the corner words of each accepted segment and holds them until they
	// come back from the block.
	class corner_book;
		corner_t due[$];
		logic [pci_pkg::LEN_W-1:0] min_len;
		line_t first_line;
		line_t prev_line;
		int unsigned kept;
		int unsigned errors;

		function new();
			min_len = pci_pkg::LEN_RESET;
			first_line = '{0, 0, 0};
			prev_line = '{0, 0, 0};
			kept = 0;
			errors = 0;
		endfunction

		function logic signed [pci_pkg::RES_W-1:0] clip16(longint v);
			if (v > 32767)
				return pci_pkg::RES_MAX;
			if (v < -32768)
				return pci_pkg::RES_MIN;
			return v[pci_pkg::RES_W-1:0];
		endfunction

		// Cramer's rule on the previous line p and the new or first line q.
		function bit meet(line_t p, line_t q, output corner_t c);
			longint det;
			det = p.a * q.b - q.a * p.b;
			c = '0;
			if (det == 0)
				return 0;
			c.x = clip16((q.b * p.c - p.b * q.c) / det);
			c.y = clip16((p.a * q.c - q.a * p.c) / det);
			return 1;
		endfunction

		function void take_segment(segment_t s);
			longint dx;
			longint dy;
			longint lim;
			line_t cur;
			corner_t c;
			corner_t found[$];
			dx = longint'(s.ex) - longint'(s.sx);
			dy = longint'(s.ey) - longint'(s.sy);
			lim = longint'(min_len);
			if (dx * dx + dy * dy > lim * lim) begin
				cur.a = dy;
				cur.b = longint'(s.sx) - longint'(s.ex);
				cur.c = cur.a * longint'(s.sx) + cur.b * longint'(s.sy);
				if (kept == 0) begin
					first_line = cur;
				end else if (meet(prev_line, cur, c)) begin
					found = {found, c};
				end
				prev_line = cur;
				if (kept < 2)
					kept++;
			end
			if (s.closes) begin
				if (kept > 0 && meet(prev_line, first_line, c)) begin
					c.closing = 1'b1;
					found = {found, c};
				end
				kept = 0;
			end
			if (found.size() > 0)
				found[found.size() - 1].tail = 1'b1;
			foreach (found[i])
				due = {due, found[i]};
		endfunction

		function void flag(string what, corner_t want, corner_t got);
			errors++;
			if (errors <= 10) begin
				$write("corner mismatch (%s): expected x=%0d y=%0d closing=%0b last=%0b",
					what, want.x, want.y, want.closing, want.tail);
				$display(", got x=%0d y=%0d closing=%0b last=%0b",
					got.x, got.y, got.closing, got.tail);
			end
		endfunction

		function void match_corner(corner_t got);
			corner_t want;
			if (due.size() == 0) begin
				flag("no corner due", '0, got);
				return;
			end
			want = due.pop_front();
			if (want.x !== got.x || want.y !== got.y || want.closing !== got.closing ||
					want.tail !== got.tail)
				flag("field", want, got);
		endfunction

		function void close_out();
			foreach (due[i])
				flag("never returned", due[i], '0);
			due.delete();
		endfunction

		function bit drained();
			return due.size() == 0;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [pci_pkg::LEN_W-1:0] cfg_wdata;

	pci_seg_if #(.COORD_BITS(CB)) seg_ch ();
	pci_corner_if corner_ch ();

	corner_book book = new();

	int burst_left = 0;
	int segments_sent = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int pat_left = 0;
	int pat_mode = 0;
	logic [7:0] pat_mask = 8'hFF;
	corner_t got_word;

	polygon_corner_intersector_unit #(.COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg(seg_ch),
		.corner(corner_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Receiver: drive ready at the rising edge. A hold-off request from the main
	// sequence parks ready low for a long stretch, counted here; otherwise switch
	// between stall patterns: always ready, coin flips, a rotating mask, mostly ready.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			corner_ch.ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_mode = $urandom_range(0, 3);
				pat_mask = 8'($urandom());
				pat_left = $urandom_range(16, 200);
			end
			pat_left--;
			pat_mask = {pat_mask[6:0], pat_mask[7]};
			case (pat_mode)
				0: corner_ch.ready <= 1'b1;
				1: corner_ch.ready <= 1'($urandom_range(0, 1));
				2: corner_ch.ready <= pat_mask[0];
				default: corner_ch.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Sample the result channel mid-cycle, where everything driven at the edge has
	// settled; a word seen with valid and ready is taken at the next rising edge.
	always @(negedge clk) begin
		if (corner_ch.valid === 1'b1 && corner_ch.ready === 1'b1) begin
			got_word.x = corner_ch.corner_x;
			got_word.y = corner_ch.corner_y;
			got_word.closing = corner_ch.is_closing_corner;
			got_word.tail = corner_ch.last_of_run;
			book.match_corner(got_word);
		end
	end

	// Watchdog: count cycles in which no word moves on either channel.
	always @(negedge clk) begin
		if ((seg_ch.valid === 1'b1 && seg_ch.ready === 1'b1) ||
				(corner_ch.valid === 1'b1 && corner_ch.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("polygon_corner_intersector_unit_tb NOT OK");
			$finish;
		end
	end

	function automatic segment_t mk(int sx, int sy, int ex, int ey, bit cl);
		segment_t s;
		s.sx = sx[CB-1:0];
		s.sy = sy[CB-1:0];
		s.ex = ex[CB-1:0];
		s.ey = ey[CB-1:0];
		s.closes = cl;
		return s;
	endfunction

	// Bias vertices toward the borders so that long diagonals and extreme
	// coordinates turn up often.
	function automatic int pick_coord();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return CMAX;
			2, 3: return $urandom_range(0, 255);
			4, 5: return $urandom_range(CMAX - 255, CMAX);
			default: return $urandom_range(0, CMAX);
		endcase
	endfunction

	// A segment of a few pixels at most, starting from (x, y).
	function automatic segment_t short_seg(int x, int y, bit cl);
		int dx;
		int dy;
		dx = $urandom_range(0, 3);
		dy = $urandom_range(0, 3);
		return mk(x, y, (x > CMAX - 4) ? x - dx : x + dx,
			(y > CMAX - 4) ? y - dy : y + dy, cl);
	endfunction

	// Drop valid and rest the input for the given length (n >= 1).
	task automatic rest_input(int n);
		seg_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offer one segment word and hold it until taken; the sender runs in bursts
	// of random length, with an occasional long burst with no gaps at all.
	task automatic offer(segment_t s);
		seg_ch.valid <= 1'b1;
		seg_ch.start_x <= s.sx;
		seg_ch.start_y <= s.sy;
		seg_ch.end_x <= s.ex;
		seg_ch.end_y <= s.ey;
		seg_ch.closes_polygon <= s.closes;
		do @(negedge clk); while (seg_ch.ready !== 1'b1);
		book.take_segment(s);
		segments_sent++;
		@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			rest_input($urandom_range(1, 24));
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 10);
		end
	endtask

	// Hold the sender until every predicted corner is back, then let a segment
	// that yields nothing finish inside the block.
	task automatic wait_drained();
		seg_ch.valid <= 1'b0;
		while (!book.drained()) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_len(int v);
		cfg_wdata <= v[pci_pkg::LEN_W-1:0];
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.min_len = v[pci_pkg::LEN_W-1:0];
	endtask

	// A closed polygon of 3 to 8 sides. Now and then insert a tiny segment,
	// repeat a side (a parallel pair), or close with a tiny segment.
	task automatic send_polygon();
		int nseg;
		int x0;
		int y0;
		int px;
		int py;
		int nx;
		int ny;
		int r;
		segment_t s;
		nseg = $urandom_range(3, 8);
		x0 = pick_coord();
		y0 = pick_coord();
		px = x0;
		py = y0;
		for (int k = 0; k < nseg; k++) begin
			if (k == nseg - 1) begin
				nx = x0;
				ny = y0;
			end else begin
				nx = pick_coord();
				ny = pick_coord();
			end
			s = mk(px, py, nx, ny, k == nseg - 1);
			r = $urandom_range(0, 19);
			if (r == 0)
				offer(short_seg(px, py, 1'b0));
			if (r == 2 && k == nseg - 1)
				s = short_seg(px, py, 1'b1);
			offer(s);
			if (r == 1 && k != nseg - 1)
				offer(s);
			px = nx;
			py = ny;
		end
	endtask

	// Unrelated segments with a random closing bit.
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			offer(mk($urandom_range(0, CMAX), $urandom_range(0, CMAX), $urandom_range(0, CMAX),
				$urandom_range(0, CMAX), $urandom_range(0, 3) == 0));
	endtask

	task automatic run_phase(int count, bit hold_out, bit pause_mid);
		int target;
		bit paused;
		target = segments_sent + count;
		paused = 1'b0;
		// the receiver parks while the sender keeps offering, so the block backs up
		if (hold_out)
			hold_req = 1'b1;
		while (segments_sent < target) begin
			if (pause_mid && !paused && segments_sent >= target - count / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			if ($urandom_range(0, 4) != 0)
				send_polygon();
			else
				send_noise();
		end
	endtask

	// Hand-picked segments at the reset limit of 120 pixels.
	task automatic run_directed();
		// close with nothing kept, by a short segment
		offer(mk(0, 0, 10, 10, 1'b1));
		// close with a single kept line: it meets itself, no corner
		offer(mk(0, 0, CMAX, 0, 1'b1));
		// full-size square; the last side yields its corner and the closing one
		offer(mk(0, 0, CMAX, 0, 1'b0));
		offer(mk(CMAX, 0, CMAX, CMAX, 1'b0));
		offer(mk(CMAX, CMAX, 0, CMAX, 1'b0));
		offer(mk(0, CMAX, 0, 0, 1'b1));
		// parallel pair gives nothing, then a diagonal, then a short closing side
		offer(mk(0, 100, CMAX, 100, 1'b0));
		offer(mk(CMAX, 200, 0, 200, 1'b0));
		offer(mk(0, CMAX, CMAX, 0, 1'b0));
		offer(mk(7, 7, 8, 9, 1'b1));
		// exactly at the limit drops, one pixel more keeps
		offer(mk(0, 0, 120, 0, 1'b0));
		offer(mk(500, 0, 500, 121, 1'b0));
		offer(mk(0, 300, 121, 300, 1'b1));
		// shallow crossings far off the image: saturate high, then low
		offer(mk(0, 0, CMAX, 1, 1'b0));
		offer(mk(0, CMAX, CMAX, CMAX - 1, 1'b1));
		offer(mk(CMAX, 0, 0, 1, 1'b0));
		offer(mk(CMAX, CMAX, 0, CMAX - 1, 1'b1));
		// all coordinate bits high and low
		offer(mk(CMAX, CMAX, 0, 0, 1'b0));
		offer(mk(0, CMAX, CMAX, 0, 1'b0));
		offer(mk(CMAX, 0, CMAX, CMAX, 1'b1));
		// same line twice in a fresh polygon: no corner anywhere
		offer(mk(100, 100, 3000, 2000, 1'b0));
		offer(mk(100, 100, 3000, 2000, 1'b1));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		seg_ch.valid = 1'b0;
		seg_ch.start_x = '0;
		seg_ch.start_y = '0;
		seg_ch.end_x = '0;
		seg_ch.end_y = '0;
		seg_ch.closes_polygon = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 10);

		run_directed();

		// sweep the length limit: none, the largest, one pixel, random, reset value, random
		wait_drained();
		write_min_len(0);
		run_phase(400, 1'b1, 1'b0);
		wait_drained();
		write_min_len(pci_pkg::LEN_RESET | 12'hF00 | 12'h0FF);
		run_phase(200, 1'b0, 1'b0);
		wait_drained();
		write_min_len(1);
		run_phase(300, 1'b0, 1'b1);
		wait_drained();
		write_min_len($urandom_range(2, 4094));
		run_phase(400, 1'b1, 1'b0);
		wait_drained();
		write_min_len(pci_pkg::LEN_RESET);
		run_phase(400, 1'b0, 1'b1);
		wait_drained();
		write_min_len($urandom_range(500, 2000));
		run_phase(300, 1'b0, 1'b0);

		// drain, give the block time to show stray words, then judge
		wait_drained();
		book.close_out();
		if (book.errors == 0)
			$display("polygon_corner_intersector_unit_tb OK");
		else
			$display("polygon_corner_intersector_unit_tb NOT OK");
		$finish;
	end

endmodule
